FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

FILE: rtl/core/tfs_pkg.sv
package tfs_pkg;

    localparam int OP_W    = 3;
    localparam int TIME_W  = 32;
    localparam int ACC_W   = 33;
    localparam int COORD_W = 16;
    localparam int IDX_W   = 4;

    // table entry: {delay, left, top, width, height}
    localparam int ENTRY_W = TIME_W + 4 * COORD_W;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_APPEND = 3'd1,
        OP_PLAY   = 3'd2,
        OP_STOP   = 3'd3,
        OP_REWIND = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_SETTLE,
        S_DONE
    } state_t;

endpackage

FILE: rtl/core/timed_frame_sequencer.sv
// A running tick with frames stored steps through S_STEP to the done beat, one advance per
// cycle through the compare/subtract unit, until the delay is not reached, the first wrap
// with loop disabled, or MAX_ADVANCES advances. Other operations pass S_SETTLE and S_DONE.
// A new operation is taken only in S_IDLE; busy stays high until the done beat has passed.
// Reset: async active low; no frames, position 0, playing, loop disabled.
// The done beat is shown for one cycle only; the receiver cannot stall.
`include "assert_macros.svh"

module timed_frame_sequencer #(
    parameter int MAX_FRAMES   = 16,
    parameter int MAX_ADVANCES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tfs_pkg::OP_W-1:0]            operation,
    input  logic [tfs_pkg::TIME_W-1:0]          elapsed_us,
    input  logic [tfs_pkg::TIME_W-1:0]          frame_delay_us,
    input  logic signed [tfs_pkg::COORD_W-1:0]  in_left,
    input  logic signed [tfs_pkg::COORD_W-1:0]  in_top,
    input  logic signed [tfs_pkg::COORD_W-1:0]  in_width,
    input  logic signed [tfs_pkg::COORD_W-1:0]  in_height,
    input  logic                                cfg_we,
    input  logic                                cfg_data,
    output logic                                done,
    output logic [tfs_pkg::IDX_W-1:0]           frame_index,
    output logic signed [tfs_pkg::COORD_W-1:0]  out_left,
    output logic signed [tfs_pkg::COORD_W-1:0]  out_top,
    output logic signed [tfs_pkg::COORD_W-1:0]  out_width,
    output logic signed [tfs_pkg::COORD_W-1:0]  out_height,
    output logic                                is_playing,
    output logic                                has_frames,
    output logic                                append_rejected
);

    import tfs_pkg::*;

    localparam int PW = $clog2(MAX_FRAMES);
    localparam int SW = $clog2(MAX_FRAMES + 1);
    localparam int AW = (MAX_ADVANCES > 1) ? $clog2(MAX_ADVANCES) : 1;

    state_t            state_reg, state_next;
    logic [PW-1:0]     position_reg, position_next;
    logic [SW-1:0]     stored_reg, stored_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              passed_end_reg, passed_end_next;
    logic              playing_reg, playing_next;
    logic              loop_enable_reg;
    logic              rejected_reg, rejected_next;
    logic [AW-1:0]     adv_cnt_reg, adv_cnt_next;

    logic              accept;
    logic              full;
    logic              tick_go;
    logic              ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [TIME_W-1:0] rd_delay;
    logic [ACC_W:0]    acc_sum;
    logic              acc_ge;
    logic [SW-1:0]     pos_inc;
    logic              wrap;
    logic              last_adv;
    logic              stop_at_wrap;
    logic              step_end;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign full     = (stored_reg == SW'(MAX_FRAMES));
    assign tick_go  = (operation == OP_TICK) && playing_reg && (stored_reg != '0);
    assign ram_we   = accept && (operation == OP_APPEND) && !full;
    assign ram_wdata = {frame_delay_us, in_left, in_top, in_width, in_height};

    tfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FRAMES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (PW'(stored_reg)),
        .wdata (ram_wdata),
        .raddr (position_next),
        .rdata (ram_rdata)
    );

    assign rd_delay     = ram_rdata[ENTRY_W-1 -: TIME_W];
    assign acc_sum      = {1'b0, acc_reg} + (ACC_W + 1)'(elapsed_us);
    assign acc_ge       = (acc_reg >= {1'b0, rd_delay});
    assign pos_inc      = SW'(position_reg) + SW'(1);
    assign wrap         = (pos_inc >= stored_reg);
    assign last_adv     = (adv_cnt_reg == AW'(MAX_ADVANCES - 1));
    assign stop_at_wrap = wrap && !passed_end_reg && !loop_enable_reg;
    assign step_end     = !acc_ge || stop_at_wrap || last_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            position_reg    <= '0;
            stored_reg      <= '0;
            acc_reg         <= '0;
            passed_end_reg  <= 1'b0;
            playing_reg     <= 1'b1;
            loop_enable_reg <= 1'b0;
            rejected_reg    <= 1'b0;
            adv_cnt_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            position_reg   <= position_next;
            stored_reg     <= stored_next;
            acc_reg        <= acc_next;
            passed_end_reg <= passed_end_next;
            playing_reg    <= playing_next;
            rejected_reg   <= rejected_next;
            adv_cnt_reg    <= adv_cnt_next;
            if (cfg_we)
            begin
                loop_enable_reg <= cfg_data;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = tick_go ? S_STEP : S_SETTLE;
                end
            end
            S_STEP:
            begin
                if (step_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_SETTLE: state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        position_next   = position_reg;
        stored_next     = stored_reg;
        acc_next        = acc_reg;
        passed_end_next = passed_end_reg;
        playing_next    = playing_reg;
        rejected_next   = rejected_reg;
        adv_cnt_next    = adv_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rejected_next = 1'b0;
                    adv_cnt_next  = '0;
                    case (operation)
                        OP_TICK:
                        begin
                            if (tick_go)
                            begin
                                acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                            end
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                stored_next = stored_reg + SW'(1);
                            end
                        end
                        OP_PLAY:   playing_next = 1'b1;
                        OP_STOP:   playing_next = 1'b0;
                        OP_REWIND:
                        begin
                            position_next   = '0;
                            passed_end_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_STEP:
            begin
                if (acc_ge)
                begin
                    acc_next      = acc_reg - {1'b0, rd_delay};
                    adv_cnt_next  = adv_cnt_reg + AW'(1);
                    position_next = wrap ? '0 : PW'(pos_inc);
                    if (wrap && !passed_end_reg)
                    begin
                        passed_end_next = 1'b1;
                        if (!loop_enable_reg)
                        begin
                            playing_next = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign done            = (state_reg == S_DONE);
    assign has_frames      = (stored_reg != '0);
    assign is_playing      = playing_reg;
    assign append_rejected = rejected_reg;
    assign frame_index     = has_frames ? IDX_W'(position_reg) : '0;
    assign out_left   = has_frames ? ram_rdata[4*COORD_W-1 -: COORD_W] : '0;
    assign out_top    = has_frames ? ram_rdata[3*COORD_W-1 -: COORD_W] : '0;
    assign out_width  = has_frames ? ram_rdata[2*COORD_W-1 -: COORD_W] : '0;
    assign out_height = has_frames ? ram_rdata[COORD_W-1 -: COORD_W] : '0;

    `ASSERT_CLK(a_accept_busy, clk, rst_n, accept |=> busy, "accepted beat did not raise busy")
    `ASSERT_CLK(a_done_idle, clk, rst_n, done |=> !busy, "not ready after done beat")
    `ASSERT_CLK(a_empty_index, clk, rst_n, (has_frames || frame_index == '0), "index set with no frames")
    `ASSERT_CLK(a_reject_full, clk, rst_n, (done && append_rejected) |-> full, "reject without full table")

endmodule

FILE: rtl/core/tfs_ram.sv
module tfs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
